FILE: hdl/recurring_timer_queue_macros.svh
// Assertion macros used by the timer queue datapath.
// No dependencies; include by bare file name.
`ifndef RECURRING_TIMER_QUEUE_MACROS_SVH
`define RECURRING_TIMER_QUEUE_MACROS_SVH

// same-cycle implication
`define RTQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rtq_pkg.sv
// Shared constants, op codes and controller/datapath interface types.
// No dependencies.
package rtq_pkg;

  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 32;
  localparam int MAX_OUT   = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int SLOT_ID_W = 4;
  localparam int OP_W      = 2;
  localparam int CNT_W     = $clog2(MAX_OUT + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ARM    = 2'd0,
    OP_DISARM = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic emit_fire;
    logic emit_idle;
  } rtq_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic any_due;
    logic scan_end;
    logic out_free;
    logic last;
  } rtq_stat_t;

endpackage

FILE: hdl/rtq_ctrl.sv
// Sequencing state machine of the timer queue.
// Depends on rtq_pkg; drives commands into rtq_datapath.
module rtq_ctrl
  import rtq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  rtq_stat_t stat,
  output rtq_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EMIT = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = (stat.is_tick && stat.any_due) ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_end) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_fire = 1'b1;
          state_next    = stat.last ? S_IDLE : S_SCAN;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.emit_idle = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/rtq_datapath.sv
// Slot table, due-order scan and output register of the timer queue.
// Depends on rtq_pkg and the assertion macro header; driven by rtq_ctrl.
`include "recurring_timer_queue_macros.svh"
module rtq_datapath
  import rtq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [OP_W-1:0]      op,
  input  logic [SLOT_ID_W-1:0] slot_id,
  input  logic [TIME_BITS-1:0] due_time,
  input  logic [TIME_BITS-1:0] repeat_interval,
  input  logic [TIME_BITS-1:0] now_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 fired,
  output logic [SLOT_ID_W-1:0] fired_slot,
  output logic                 last,
  input  rtq_cmd_t             cmd,
  output rtq_stat_t            stat
);

  logic [TIME_BITS-1:0] due_mem [SLOTS];
  logic [TIME_BITS-1:0] per_mem [SLOTS];
  logic [SLOTS-1:0]     armed;
  logic [SLOTS-1:0]     elig;
  logic [SLOTS-1:0]     due_ok;
  logic [SLOT_W-1:0]    idx;
  logic [CNT_W-1:0]     cnt;
  logic                 best_vld;
  logic [SLOT_W-1:0]    best_slot;
  logic [TIME_BITS-1:0] best_due;

  logic                 slot_ok;
  logic [SLOT_W-1:0]    arm_idx;
  logic [TIME_BITS-1:0] floor_t;
  logic [TIME_BITS-1:0] arm_due;
  logic [TIME_BITS-1:0] cur_due;
  logic                 take;
  logic                 scan_end;
  logic [TIME_BITS-1:0] best_per;
  logic [TIME_BITS:0]   due_sum;
  logic [TIME_BITS-1:0] due_adv;
  logic [SLOTS-1:0]     best_mask;
  logic                 last_flag;
  logic                 out_free;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      due_ok[i] = armed[i] && (due_mem[i] <= now_time);
    end
  end

  assign slot_ok   = (int'(slot_id) < SLOTS);
  assign arm_idx   = SLOT_W'(slot_id);
  assign floor_t   = (now_time >= repeat_interval) ? (now_time - repeat_interval) : '0;
  assign arm_due   = (due_time > floor_t) ? due_time : floor_t;
  assign cur_due   = due_mem[idx];
  assign take      = elig[idx] && (!best_vld || (cur_due < best_due));
  assign scan_end  = (idx == SLOT_W'(SLOTS - 1));
  assign best_per  = per_mem[best_slot];
  assign due_sum   = {1'b0, best_due} + {1'b0, best_per};
  assign due_adv   = due_sum[TIME_BITS] ? '1 : due_sum[TIME_BITS-1:0];
  assign best_mask = SLOTS'(1) << best_slot;
  assign last_flag = ((elig & ~best_mask) == '0) || (cnt == CNT_W'(MAX_OUT - 1));
  assign out_free  = !out_valid || !out_stall;

  assign stat.is_tick  = (op == OP_TICK);
  assign stat.any_due  = (due_ok != '0);
  assign stat.scan_end = scan_end;
  assign stat.out_free = out_free;
  assign stat.last     = last_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= '0;
      elig      <= '0;
      idx       <= '0;
      cnt       <= '0;
      best_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx      <= '0;
        cnt      <= '0;
        best_vld <= 1'b0;
        case (op)
          OP_ARM: begin
            if (slot_ok) begin
              armed[arm_idx] <= 1'b1;
            end
          end
          OP_DISARM: begin
            if (slot_ok) begin
              armed[arm_idx] <= 1'b0;
            end
          end
          OP_TICK: begin
            elig <= due_ok;
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan_step) begin
        idx <= scan_end ? '0 : idx + 1'b1;
        if (take) begin
          best_vld <= 1'b1;
        end
      end
      if (cmd.emit_fire) begin
        elig[best_slot] <= 1'b0;
        cnt             <= cnt + 1'b1;
        best_vld        <= 1'b0;
        if (best_per == '0) begin
          armed[best_slot] <= 1'b0;
        end
      end
      if (cmd.emit_fire || cmd.emit_idle) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (op == OP_ARM) && slot_ok) begin
      due_mem[arm_idx] <= arm_due;
      per_mem[arm_idx] <= repeat_interval;
    end else if (cmd.emit_fire && (best_per != '0)) begin
      due_mem[best_slot] <= due_adv;
    end
    if (cmd.scan_step && take) begin
      best_due  <= cur_due;
      best_slot <= idx;
    end
    if (cmd.emit_fire) begin
      fired      <= 1'b1;
      fired_slot <= SLOT_ID_W'(best_slot);
      last       <= last_flag;
    end else if (cmd.emit_idle) begin
      fired      <= 1'b0;
      fired_slot <= '0;
      last       <= 1'b1;
    end
  end

  `RTQ_ASSERT_NOW(a_fire_has_pick, clk, rst, cmd.emit_fire, best_vld && elig[best_slot], "fire without a picked slot")
  `RTQ_ASSERT_NOW(a_load_when_free, clk, rst, cmd.emit_fire || cmd.emit_idle, out_free, "result loaded over a pending transfer")
  `RTQ_ASSERT_NEXT(a_last_drains, clk, rst, cmd.emit_fire && last_flag, (elig == '0) || (cnt == CNT_W'(MAX_OUT)), "last result left due slots behind")

endmodule

FILE: hdl/recurring_timer_queue.sv
// Recurring timer queue: arm, disarm and tick over a table of 16 timer slots.
// Arm, disarm, unknown ops and a tick with nothing due: one result, loaded into the output
// register from the response state after accept. Tick firing k slots (at most 16 results):
// each result takes a walk over the 16-slot table, then one load from the emit state.
// The next item is taken the cycle after the final load; a held output delays each load.
// Reset clears all armed bits, the controller and the output valid; due and period entries stay unset.
module recurring_timer_queue
  import rtq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      op,
  input  logic [SLOT_ID_W-1:0] slot_id,
  input  logic [TIME_BITS-1:0] due_time,
  input  logic [TIME_BITS-1:0] repeat_interval,
  input  logic [TIME_BITS-1:0] now_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 fired,
  output logic [SLOT_ID_W-1:0] fired_slot,
  output logic                 last
);

  rtq_cmd_t  cmd;
  rtq_stat_t stat;

  rtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtq_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .slot_id         (slot_id),
    .due_time        (due_time),
    .repeat_interval (repeat_interval),
    .now_time        (now_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .fired           (fired),
    .fired_slot      (fired_slot),
    .last            (last),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule
